// File: design/qbp_pkg.sv
// Shared types, constants and glyph table for the quadrant block plot buffer.
package qbp_pkg;

  localparam int CFG_W      = 9;
  localparam int IDX_W      = 2;
  localparam int COLS_REG_W = 9;
  localparam int ROWS_REG_W = 4;

  localparam logic [IDX_W-1:0] REG_COLUMNS = 2'd0;
  localparam logic [IDX_W-1:0] REG_ROWS    = 2'd1;

  localparam logic [COLS_REG_W-1:0] COLUMNS_RESET = 9'd80;
  localparam logic [ROWS_REG_W-1:0] ROWS_RESET    = 4'd8;

  localparam logic       CMD_PLOT = 1'b0;
  localparam logic       CMD_EMIT = 1'b1;

  localparam logic [7:0] BYTE_SPACE   = 8'h20;
  localparam logic [7:0] BYTE_NEWLINE = 8'h0A;
  localparam logic [7:0] BYTE_LEAD    = 8'hE2;
  localparam logic [7:0] BYTE_MID     = 8'h96;
  localparam logic [7:0] BYTE_TAIL    = 8'h80;

  typedef struct packed {
    logic       capture;
    logic       calc;
    logic       read;
    logic       write;
    logic       load;
    logic       advance;
    logic       clear;
    logic [1:0] byte_sel;
    logic       byte_last;
  } cmd_t;

  typedef struct packed {
    logic       clear_done;
    logic       is_emit;
    logic       out_free;
    logic [1:0] byte_max;
  } stat_t;

  // low six bits of the glyph code point above U+2580
  function automatic logic [5:0] glyph_off(input logic [3:0] mask);
    logic [5:0] r;
    case (mask)
      4'd1:    r = 6'h18;
      4'd2:    r = 6'h1D;
      4'd3:    r = 6'h00;
      4'd4:    r = 6'h16;
      4'd5:    r = 6'h0C;
      4'd6:    r = 6'h1E;
      4'd7:    r = 6'h1B;
      4'd8:    r = 6'h17;
      4'd9:    r = 6'h1A;
      4'd10:   r = 6'h10;
      4'd11:   r = 6'h1C;
      4'd12:   r = 6'h04;
      4'd13:   r = 6'h19;
      4'd14:   r = 6'h1F;
      4'd15:   r = 6'h08;
      default: r = 6'h00;
    endcase
    return r;
  endfunction

endpackage

// File: design/qbp_ctrl.sv
// Controller state machine: clear sweep, item sequencing and byte sending.
module qbp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  qbp_pkg::stat_t stat,
  output qbp_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CALC  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_ACT   = 3'd4;
  localparam logic [2:0] S_SEND  = 3'd5;

  logic [2:0] state, state_next;
  logic [1:0] k, k_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    k_next        = k;
    cmd           = '0;
    cmd.byte_sel  = k;
    cmd.byte_last = (k == stat.byte_max);
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_ACT;
      end
      S_ACT: begin
        if (stat.is_emit == qbp_pkg::CMD_EMIT) begin
          k_next     = 2'd0;
          state_next = S_SEND;
        end else begin
          cmd.write  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SEND: begin
        if (stat.out_free) begin
          cmd.load = 1'b1;
          if (k == stat.byte_max) begin
            cmd.advance = 1'b1;
            state_next  = S_IDLE;
          end else begin
            k_next = k + 2'd1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      k     <= 2'd0;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

endmodule

// File: design/qbp_datapath.sv
// Datapath: registers, cell store, address math, cursor and output byte register.
module qbp_datapath #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [qbp_pkg::IDX_W-1:0]   wr_index,
  input  logic [qbp_pkg::CFG_W-1:0]   wr_data,
  input  logic                        cmd_in,
  input  logic signed [15:0]          x,
  input  logic signed [15:0]          y,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic [7:0]                  out_byte,
  output logic                        last,
  output logic                        frame_end,
  input  qbp_pkg::cmd_t               cmd,
  output qbp_pkg::stat_t              stat
);

  localparam int DEPTH  = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int NC_W   = $clog2(MAX_COLS + 1);
  localparam int NR_W   = $clog2(MAX_ROWS + 1);
  localparam int PW     = ROW_W + NC_W;

  logic [qbp_pkg::COLS_REG_W-1:0] columns;
  logic [qbp_pkg::ROWS_REG_W-1:0] rows;
  logic [NC_W-1:0] nc;
  logic [NR_W-1:0] nr;

  logic        cmd_q;
  logic [15:0] x_q, y_q;

  logic [COL_W-1:0] cur_col, ecol, sel_col;
  logic [ROW_W-1:0] cur_row, erow, sel_row;
  logic             wrap, row_end, last_row, inb;
  logic [PW-1:0]    prod, sum;

  logic [ADDR_W-1:0] idx_q, clr_cnt;
  logic              inb_q, row_end_q, fe_q;
  logic [3:0]        bit_q, rdata;
  logic [3:0]        mem [DEPTH];

  logic       empty;
  logic [1:0] glyph_n;
  logic [7:0] sel_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns <= qbp_pkg::COLUMNS_RESET;
      rows    <= qbp_pkg::ROWS_RESET;
    end else if (wr_en) begin
      case (wr_index)
        qbp_pkg::REG_COLUMNS: columns <= wr_data[qbp_pkg::COLS_REG_W-1:0];
        qbp_pkg::REG_ROWS:    rows    <= wr_data[qbp_pkg::ROWS_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (columns == '0) nc = NC_W'(1);
    else if (32'(columns) > 32'(MAX_COLS)) nc = NC_W'(MAX_COLS);
    else nc = NC_W'(columns);
    if (rows == '0) nr = NR_W'(1);
    else if (32'(rows) > 32'(MAX_ROWS)) nr = NR_W'(MAX_ROWS);
    else nr = NR_W'(rows);
  end

  always_comb begin
    wrap     = (NC_W'(cur_col) >= nc) || (NR_W'(cur_row) >= nr);
    ecol     = wrap ? '0 : cur_col;
    erow     = wrap ? '0 : cur_row;
    sel_col  = cmd_q ? ecol : x_q[COL_W:1];
    sel_row  = cmd_q ? erow : y_q[ROW_W:1];
    prod     = PW'(sel_row) * PW'(nc);
    sum      = prod + PW'(sel_col);
    row_end  = (NC_W'(ecol) + NC_W'(1)) == nc;
    last_row = (NR_W'(erow) + NR_W'(1)) == nr;
    inb      = !x_q[15] && !y_q[15] &&
               ({1'b0, x_q[14:0]} < 16'({nc, 1'b0})) &&
               ({1'b0, y_q[14:0]} < 16'({nr, 1'b0}));
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q <= cmd_in;
      x_q   <= x;
      y_q   <= y;
    end
    if (cmd.calc) begin
      idx_q     <= sum[ADDR_W-1:0];
      inb_q     <= inb;
      bit_q     <= 4'b0001 << {y_q[0], x_q[0]};
      row_end_q <= row_end;
      fe_q      <= row_end && last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col <= '0;
      cur_row <= '0;
    end else if (cmd.calc && cmd_q) begin
      cur_col <= ecol;
      cur_row <= erow;
    end else if (cmd.advance) begin
      if (row_end_q) begin
        cur_col <= '0;
        cur_row <= fe_q ? '0 : cur_row + ROW_W'(1);
      end else begin
        cur_col <= cur_col + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clr_cnt] <= 4'd0;
    end else if (cmd.write && inb_q) begin
      mem[idx_q] <= rdata | bit_q;
    end
    if (cmd.read) begin
      rdata <= mem[idx_q];
    end
  end

  always_comb begin
    empty   = (rdata == 4'd0);
    glyph_n = empty ? 2'd1 : 2'd3;
    if (row_end_q && cmd.byte_sel == glyph_n) begin
      sel_byte = qbp_pkg::BYTE_NEWLINE;
    end else if (empty) begin
      sel_byte = qbp_pkg::BYTE_SPACE;
    end else begin
      case (cmd.byte_sel)
        2'd0:    sel_byte = qbp_pkg::BYTE_LEAD;
        2'd1:    sel_byte = qbp_pkg::BYTE_MID;
        default: sel_byte = qbp_pkg::BYTE_TAIL | {2'b00, qbp_pkg::glyph_off(rdata)};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.load) begin
      out_byte  <= sel_byte;
      last      <= cmd.byte_last;
      frame_end <= fe_q;
    end
  end

  assign stat.clear_done = (clr_cnt == ADDR_W'(DEPTH - 1));
  assign stat.is_emit    = cmd_q;
  assign stat.out_free   = !out_valid || !out_stall;
  assign stat.byte_max   = (empty ? 2'd0 : 2'd2) + {1'b0, row_end_q};

endmodule

// File: design/quadrant_block_plot_buffer_top.sv
// Top level of the quadrant block plot buffer: controller, datapath and checks.
//
//   channel  direction  handshake             payload
//   input    in         in_valid / in_stall   cmd, x, y
//   output   out        out_valid / out_stall out_byte, last, frame_end
//   config   in         wr_en                 wr_index, wr_data
//
// A plot item passes through accept, address multiply, store read and store write.
// An emit item passes through accept, address multiply and store read, then sends
// its 1 to 4 bytes through the byte-wide output register; a stalled output
// holds the sequencer. After reset the store is cleared one cell a cycle
// over every cell, with in_stall high; configuration writes are taken meanwhile.
module quadrant_block_plot_buffer_top #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [qbp_pkg::IDX_W-1:0]   wr_index,
  input  logic [qbp_pkg::CFG_W-1:0]   wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        cmd,
  input  logic signed [15:0]          x,
  input  logic signed [15:0]          y,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_byte,
  output logic                        last,
  output logic                        frame_end
);

  qbp_pkg::cmd_t  ctl;
  qbp_pkg::stat_t stat;

  qbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (ctl)
  );

  qbp_datapath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .cmd_in    (cmd),
    .x         (x),
    .y         (y),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .last      (last),
    .frame_end (frame_end),
    .cmd       (ctl),
    .stat      (stat)
  );

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted while another is in work");

  a_clear_stall: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> in_stall)
    else $error("input open before store clear");

  a_bytes_gapless: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last) |=> out_valid)
    else $error("gap inside the bytes of one item");

  a_fe_steady: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last) |=> (frame_end == $past(frame_end)))
    else $error("frame_end changed within one item");

endmodule
